// File: src/pst_pkg.sv
// shared types and constants for the path string tokenizer
// no dependencies; compiled before every other file of the block
package pst_pkg;

  localparam int CH_W    = 8;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int COUNT_W = 12;

  // depth of the queue between classifier and tokenizer core
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_USCORE = 8'h5F;
  localparam logic [CH_W-1:0] CH_DASH   = 8'h2D;

  // character class of one beat as the core sees it
  typedef struct packed {
    logic last;
    logic sep;
    logic slash;
    logic dot;
    logic bad_char;
  } cls_t;

  // queue head as seen by the core
  typedef struct packed {
    logic valid;
    cls_t data;
  } qhead_t;

  typedef struct packed {
    logic [START_W-1:0] comp_start;
    logic [LEN_W-1:0]   comp_length;
    logic               is_final;
    logic               valid_res;
    logic               has_root;
    logic               ends_with_sep;
    logic [COUNT_W-1:0] comp_count;
    logic               has_file_name;
    logic [LEN_W-1:0]   title_length;
    logic               has_extension;
    logic [LEN_W-1:0]   dir_length;
    logic [LEN_W-1:0]   path_length;
  } res_t;

endpackage

// File: src/pst_in_if.sv
// character channel: valid/ready with one path character per beat
// depends on pst_pkg
interface pst_in_if;
  import pst_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

// File: src/pst_out_if.sv
// result channel: valid/ready with one component or summary per beat
// depends on pst_pkg
interface pst_out_if;
  import pst_pkg::*;

  logic               valid;
  logic               ready;
  logic [START_W-1:0] comp_start;
  logic [LEN_W-1:0]   comp_length;
  logic               is_final;
  logic               valid_res;
  logic               has_root;
  logic               ends_with_sep;
  logic [COUNT_W-1:0] comp_count;
  logic               has_file_name;
  logic [LEN_W-1:0]   title_length;
  logic               has_extension;
  logic [LEN_W-1:0]   dir_length;
  logic [LEN_W-1:0]   path_length;

  modport source (output valid, comp_start, comp_length, is_final, valid_res, has_root,
                  ends_with_sep, comp_count, has_file_name, title_length, has_extension,
                  dir_length, path_length, input ready);
  modport sink   (input valid, comp_start, comp_length, is_final, valid_res, has_root,
                  ends_with_sep, comp_count, has_file_name, title_length, has_extension,
                  dir_length, path_length, output ready);
endinterface

// File: src/pst_front.sv
// front end: takes character beats and classifies them for the queue
// depends on pst_pkg and pst_in_if
module pst_front (
  pst_in_if.sink       in_bus,
  input  logic         q_full,
  output logic         push,
  output pst_pkg::cls_t push_data
);
  import pst_pkg::*;

  logic is_alpha;
  logic is_digit;
  logic is_punct;
  logic sep;

  always_comb begin
    is_alpha = ((in_bus.ch >= 8'h61) && (in_bus.ch <= 8'h7A)) ||
               ((in_bus.ch >= 8'h41) && (in_bus.ch <= 8'h5A));
    is_digit = (in_bus.ch >= 8'h30) && (in_bus.ch <= 8'h39);
    sep      = (in_bus.ch == CH_SLASH) || (in_bus.ch == CH_BSLASH);
    is_punct = (in_bus.ch == CH_USCORE) || (in_bus.ch == CH_DASH) || (in_bus.ch == CH_DOT);

    push_data.last     = in_bus.last;
    push_data.sep      = sep;
    push_data.slash    = (in_bus.ch == CH_SLASH);
    push_data.dot      = (in_bus.ch == CH_DOT);
    push_data.bad_char = !(is_alpha || is_digit || is_punct || sep);
  end

  assign in_bus.ready = !q_full;
  assign push         = in_bus.valid && !q_full;

endmodule

// File: src/pst_queue.sv
// short queue of classified beats between front end and core
// depends on pst_pkg
module pst_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pst_pkg::cls_t  push_data,
  input  logic           pop,
  output logic           full,
  output pst_pkg::qhead_t head
);
  import pst_pkg::*;

  cls_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              do_pop;

  assign full       = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (fill_r != '0);
  assign head.data  = mem[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/pst_core.sv
// tokenizer core: running path state, component and summary results
// depends on pst_pkg and pst_out_if; fed from pst_queue
module pst_core #(
  parameter int MAX_PATH_LEN = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pst_pkg::qhead_t head,
  output logic            pop,
  pst_out_if.source       out_bus
);
  import pst_pkg::*;

  localparam int PW        = $clog2(MAX_PATH_LEN + 1);
  localparam int COUNT_CAP = (MAX_PATH_LEN + 1) / 2;
  localparam int CW        = $clog2(COUNT_CAP + 1);
  localparam logic [PW-1:0] MAX_P = PW'(MAX_PATH_LEN);
  localparam logic [CW-1:0] CAP_C = CW'(COUNT_CAP);

  logic [PW-1:0] pos_r, pos_nxt;
  logic          prev_sep_r, prev_sep_nxt;
  logic          root_r, root_nxt;
  logic          bad_r, bad_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] cstart_r, cstart_nxt;
  logic [PW-1:0] dot_off_r, dot_off_nxt;
  logic          dot_r, dot_nxt;
  logic [PW-1:0] slash_end_r, slash_end_nxt;

  logic          out_valid_r, out_valid_nxt;
  res_t          res_r, res_nxt;

  cls_t          c;
  logic [PW-1:0] next_pos;
  logic [PW:0]   clen;
  logic          has_comp;
  logic [CW-1:0] cnt_upd;
  logic          bad_upd, root_upd, dot_upd, fname;
  logic [PW-1:0] dot_off_upd, slash_upd;
  logic          emit;

  assign c   = head.data;
  assign pop = head.valid && (!out_valid_r || out_bus.ready);

  always_comb begin
    next_pos    = (pos_r < MAX_P) ? pos_r + 1'b1 : MAX_P;
    bad_upd     = bad_r || c.bad_char || (c.sep && prev_sep_r) || (pos_r >= MAX_P);
    root_upd    = root_r || ((pos_r == '0) && c.sep);
    dot_upd     = c.dot ? 1'b1 : dot_r;
    dot_off_upd = c.dot ? pos_r - cstart_r : dot_off_r;
    slash_upd   = c.slash ? next_pos : slash_end_r;
    // separator does not belong to the component it closes
    clen        = c.sep ? {1'b0, pos_r} - {1'b0, cstart_r}
                        : {1'b0, pos_r} + 1'b1 - {1'b0, cstart_r};
    has_comp    = (clen != '0);
    cnt_upd     = (has_comp && (cnt_r < CAP_C)) ? cnt_r + 1'b1 : cnt_r;
    fname       = !c.sep && (cnt_upd != '0);
    emit        = c.last || (c.sep && has_comp);

    pos_nxt       = pos_r;
    prev_sep_nxt  = prev_sep_r;
    root_nxt      = root_r;
    bad_nxt       = bad_r;
    cnt_nxt       = cnt_r;
    cstart_nxt    = cstart_r;
    dot_off_nxt   = dot_off_r;
    dot_nxt       = dot_r;
    slash_end_nxt = slash_end_r;

    res_nxt = '0;
    if (has_comp && (!c.last || !bad_upd)) begin
      res_nxt.comp_start  = START_W'(cstart_r);
      res_nxt.comp_length = LEN_W'(clen);
    end
    if (c.last) begin
      res_nxt.is_final    = 1'b1;
      res_nxt.path_length = LEN_W'(next_pos);
      if (!bad_upd) begin
        res_nxt.valid_res     = 1'b1;
        res_nxt.has_root      = root_upd;
        res_nxt.ends_with_sep = c.sep;
        res_nxt.comp_count    = COUNT_W'(cnt_upd);
        res_nxt.has_file_name = fname;
        if (fname) begin
          res_nxt.title_length  = dot_upd ? LEN_W'(dot_off_upd) : LEN_W'(clen);
          res_nxt.has_extension = dot_upd;
        end
        res_nxt.dir_length = LEN_W'(slash_upd);
      end
    end

    if (pop) begin
      if (c.last) begin
        // path done, back to the reset state for the next one
        pos_nxt       = '0;
        prev_sep_nxt  = 1'b0;
        root_nxt      = 1'b0;
        bad_nxt       = 1'b0;
        cnt_nxt       = '0;
        cstart_nxt    = '0;
        dot_off_nxt   = '0;
        dot_nxt       = 1'b0;
        slash_end_nxt = '0;
      end else begin
        pos_nxt       = next_pos;
        prev_sep_nxt  = c.sep;
        root_nxt      = root_upd;
        bad_nxt       = bad_upd;
        slash_end_nxt = slash_upd;
        if (c.sep) begin
          cnt_nxt     = cnt_upd;
          cstart_nxt  = next_pos;
          dot_nxt     = 1'b0;
          dot_off_nxt = '0;
        end else begin
          dot_nxt     = dot_upd;
          dot_off_nxt = dot_off_upd;
        end
      end
    end

    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      prev_sep_r  <= 1'b0;
      root_r      <= 1'b0;
      bad_r       <= 1'b0;
      cnt_r       <= '0;
      cstart_r    <= '0;
      dot_off_r   <= '0;
      dot_r       <= 1'b0;
      slash_end_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      prev_sep_r  <= prev_sep_nxt;
      root_r      <= root_nxt;
      bad_r       <= bad_nxt;
      cnt_r       <= cnt_nxt;
      cstart_r    <= cstart_nxt;
      dot_off_r   <= dot_off_nxt;
      dot_r       <= dot_nxt;
      slash_end_r <= slash_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.comp_start    = res_r.comp_start;
  assign out_bus.comp_length   = res_r.comp_length;
  assign out_bus.is_final      = res_r.is_final;
  assign out_bus.valid_res     = res_r.valid_res;
  assign out_bus.has_root      = res_r.has_root;
  assign out_bus.ends_with_sep = res_r.ends_with_sep;
  assign out_bus.comp_count    = res_r.comp_count;
  assign out_bus.has_file_name = res_r.has_file_name;
  assign out_bus.title_length  = res_r.title_length;
  assign out_bus.has_extension = res_r.has_extension;
  assign out_bus.dir_length    = res_r.dir_length;
  assign out_bus.path_length   = res_r.path_length;

endmodule

// File: src/path_string_tokenizer_top.sv
// path tokenizer top level: classifier, four-entry queue, tokenizer core
// the queue registers each beat, then the core registers its result in the result register
// throughput: one character per cycle unless the output stalls; path state updates on each pop
// in_bus.ready drops only when the four-entry queue is full, i.e. the output stalls
// reset: synchronous active-low rst_n empties the queue and the output register
// and clears all path state; no clearing pass is needed
module path_string_tokenizer_top #(
  parameter int MAX_PATH_LEN = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  pst_in_if.sink    in_bus,
  pst_out_if.source out_bus
);
  import pst_pkg::*;

  logic   q_full;
  logic   push;
  cls_t   push_data;
  logic   pop;
  qhead_t head;

  pst_front u_front (
    .in_bus    (in_bus),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  pst_core #(
    .MAX_PATH_LEN (MAX_PATH_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

// File: src/pst_checker.sv
// port-level checks on the result channel of the path tokenizer
// depends on pst_pkg; bound to path_string_tokenizer_top
module pst_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pst_pkg::START_W-1:0] comp_start,
  input logic [pst_pkg::LEN_W-1:0]   comp_length,
  input logic                        is_final,
  input logic                        valid_res,
  input logic                        has_root,
  input logic                        ends_with_sep,
  input logic [pst_pkg::COUNT_W-1:0] comp_count,
  input logic                        has_file_name,
  input logic [pst_pkg::LEN_W-1:0]   title_length,
  input logic                        has_extension,
  input logic [pst_pkg::LEN_W-1:0]   dir_length,
  input logic [pst_pkg::LEN_W-1:0]   path_length
);
  import pst_pkg::*;

  // a stalled beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(comp_start) &&
      $stable(comp_length) && $stable(is_final) && $stable(path_length))
    else $error("result beat changed while stalled");

  // component beats carry no summary
  a_comp_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_final |-> !valid_res && !has_root && !ends_with_sep &&
      (comp_count == '0) && !has_file_name && (title_length == '0) &&
      !has_extension && (dir_length == '0) && (path_length == '0))
    else $error("summary fields set on a component beat");

  // rejected path reports only its length
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_final && !valid_res |-> (comp_start == '0) &&
      (comp_length == '0) && !has_root && !ends_with_sep && (comp_count == '0) &&
      !has_file_name && (dir_length == '0))
    else $error("invalid path summary carries data");

  // a file name excludes a trailing separator
  a_fname: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_file_name |-> is_final && valid_res && !ends_with_sep)
    else $error("file name flagged with trailing separator");

  a_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_extension |-> has_file_name)
    else $error("extension without file name");

endmodule

bind path_string_tokenizer_top pst_checker u_pst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .comp_start    (out_bus.comp_start),
  .comp_length   (out_bus.comp_length),
  .is_final      (out_bus.is_final),
  .valid_res     (out_bus.valid_res),
  .has_root      (out_bus.has_root),
  .ends_with_sep (out_bus.ends_with_sep),
  .comp_count    (out_bus.comp_count),
  .has_file_name (out_bus.has_file_name),
  .title_length  (out_bus.title_length),
  .has_extension (out_bus.has_extension),
  .dir_length    (out_bus.dir_length),
  .path_length   (out_bus.path_length)
);

// File: dv/path_string_tokenizer_top_test.sv
// testbench for path_string_tokenizer_top: drives paths a character per beat and
// checks every component and summary beat against an in-bench path predictor
// depends on pst_pkg, pst_in_if, pst_out_if and the block itself
`timescale 1ns / 1ps

module path_string_tokenizer_top_test;
  import pst_pkg::*;

  localparam int PATH_MAX   = 4096;
  localparam int COUNT_CAP  = (PATH_MAX + 1) / 2;
  localparam int SHORT_GOAL = 750;
  localparam int WATCHDOG   = 4000;

  typedef bit [CH_W-1:0] path_t[$];

  // tracks one path at a time and holds the beats it should produce
  class path_scoreboard;
    int unsigned pos, comps, comp_first, dot_off, slash_end;
    bit prev_sep, rooted, broken, dot_seen;
    res_t awaited[$];
    int errors, n_checked, n_invalid;

    function void clear_path();
      pos = 0; comps = 0; comp_first = 0; dot_off = 0; slash_end = 0;
      prev_sep = 0; rooted = 0; broken = 0; dot_seen = 0;
    endfunction

    function new();
      clear_path();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_char(bit [CH_W-1:0] c, bit fin);
      int unsigned p, nxt, clen;
      bit sep, legal, fname;
      res_t r;
      p = pos;
      sep = (c == CH_SLASH) || (c == CH_BSLASH);
      nxt = (p < PATH_MAX) ? p + 1 : PATH_MAX;
      legal = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
              c == CH_USCORE || c == CH_DASH || c == CH_DOT || sep;
      if (!legal || (sep && prev_sep) || p >= PATH_MAX) broken = 1;
      if (p == 0 && sep) rooted = 1;
      if (c == CH_DOT) begin
        dot_seen = 1;
        dot_off = p - comp_first;
      end
      if (c == CH_SLASH) slash_end = nxt;
      clen = sep ? p - comp_first : p + 1 - comp_first;
      r = '0;

      if (!fin) begin
        if (sep) begin
          if (clen > 0) begin
            r.comp_start = START_W'(comp_first);
            r.comp_length = LEN_W'(clen);
            if (comps < COUNT_CAP) comps++;
            awaited = {awaited, r};
          end
          comp_first = nxt;
          dot_seen = 0;
          dot_off = 0;
        end
        prev_sep = sep;
        pos = nxt;
        return;
      end

      if (clen > 0 && comps < COUNT_CAP) comps++;
      r.is_final = 1'b1;
      r.path_length = LEN_W'(nxt);
      if (!broken) begin
        fname = !sep && comps > 0;
        if (clen > 0) begin
          r.comp_start = START_W'(comp_first);
          r.comp_length = LEN_W'(clen);
        end
        r.valid_res = 1'b1;
        r.has_root = rooted;
        r.ends_with_sep = sep;
        r.comp_count = COUNT_W'(comps);
        r.has_file_name = fname;
        if (fname) begin
          r.title_length = LEN_W'(dot_seen ? dot_off : clen);
          r.has_extension = dot_seen;
        end
        r.dir_length = LEN_W'(slash_end);
      end else begin
        n_invalid++;
      end
      awaited = {awaited, r};
      clear_path();
    endfunction

    function bit field_ok(string what, int unsigned want, int unsigned got);
      if (want != got)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      return want == got;
    endfunction

    function void check_result(res_t got);
      res_t want;
      bit ok;
      if (awaited.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      ok = 1;
      ok &= field_ok("comp_start", want.comp_start, got.comp_start);
      ok &= field_ok("comp_length", want.comp_length, got.comp_length);
      ok &= field_ok("is_final", want.is_final, got.is_final);
      ok &= field_ok("valid_res", want.valid_res, got.valid_res);
      ok &= field_ok("has_root", want.has_root, got.has_root);
      ok &= field_ok("ends_with_sep", want.ends_with_sep, got.ends_with_sep);
      ok &= field_ok("comp_count", want.comp_count, got.comp_count);
      ok &= field_ok("has_file_name", want.has_file_name, got.has_file_name);
      ok &= field_ok("title_length", want.title_length, got.title_length);
      ok &= field_ok("has_extension", want.has_extension, got.has_extension);
      ok &= field_ok("dir_length", want.dir_length, got.dir_length);
      ok &= field_ok("path_length", want.path_length, got.path_length);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit calm;
  int idle_pct = 10;
  int n_chars, n_paths, n_short, quiet_cycles;
  path_scoreboard sb = new();

  pst_in_if  in_bus();
  pst_out_if out_bus();

  path_string_tokenizer_top #(.MAX_PATH_LEN(PATH_MAX)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus)
  );

  always #10 clk = ~clk;

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result({out_bus.comp_start, out_bus.comp_length, out_bus.is_final,
                       out_bus.valid_res, out_bus.has_root, out_bus.ends_with_sep,
                       out_bus.comp_count, out_bus.has_file_name, out_bus.title_length,
                       out_bus.has_extension, out_bus.dir_length, out_bus.path_length});
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts between ready runs
  initial begin
    int stall_left, run_left;
    out_bus.ready = 1'b0;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_bus.ready <= 1'b1;
        run_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_bus.ready <= 1'b1;
        run_left = $urandom_range(1, 40);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_char(bit [CH_W-1:0] c, bit fin);
    int gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 17);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.ch <= c;
    in_bus.last <= fin;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_char(c, fin);
    n_chars++;
    @(negedge clk);
  endtask

  task automatic send_path(path_t p);
    for (int i = 0; i < p.size(); i++)
      send_char(p[i], i == p.size() - 1);
    n_paths++;
  endtask

  task automatic send_text(string s);
    path_t p;
    for (int i = 0; i < s.len(); i++)
      p = {p, s[i]};
    send_path(p);
  endtask

  function automatic bit [CH_W-1:0] name_char();
    int r;
    if ($urandom_range(0, 5) == 0) return CH_DOT;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'(r) + "a";
    if (r < 52) return 8'(r - 26) + "A";
    if (r < 62) return 8'(r - 52) + "0";
    return (r == 62) ? CH_USCORE : CH_DASH;
  endfunction

  function automatic bit [CH_W-1:0] any_sep();
    return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
  endfunction

  // mostly well-formed paths, some with a fault injected, some raw bytes
  function automatic path_t make_path();
    path_t p;
    int kind, ncomp, at;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 12)) p = {p, 8'($urandom_range(0, 255))};
      return p;
    end
    if ($urandom_range(0, 2) == 0) p = {p, any_sep()};
    ncomp = $urandom_range(1, 6);
    for (int k = 0; k < ncomp; k++) begin
      repeat ($urandom_range(1, 8)) p = {p, name_char()};
      if (k < ncomp - 1) p = {p, any_sep()};
    end
    if ($urandom_range(0, 2) == 0) p = {p, any_sep()};
    if (kind >= 7) begin
      at = $urandom_range(0, p.size());
      if (kind == 7) begin
        p.insert(at, any_sep());
        p.insert(at, any_sep());
      end else begin
        p.insert(at, 8'($urandom_range(0, 255)));
      end
    end
    return p;
  endfunction

  initial begin
    path_t p;
    in_bus.valid = 1'b0;
    in_bus.ch = '0;
    in_bus.last = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // lone separator, lone name, extension, rooted dir, backslash root
    send_text("/");
    send_text("a");
    send_text("a.b");
    send_text("/x/");
    send_text("\\y");
    // doubled separator, illegal bytes at both extremes
    send_text("a//");
    p = {8'h7A, 8'hFF};
    send_path(p);
    p = {8'h00};
    send_path(p);
    // backslash does not move the directory length
    send_text("d.e\\f");

    while (n_short < SHORT_GOAL) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 8;
        default: idle_pct = 30;
      endcase
      if (n_short > SHORT_GOAL * 4 / 5) calm = 1;
      p = make_path();
      n_short += p.size();
      send_path(p);
    end
    in_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("ran %0d paths (%0d characters, %0d of them invalid)",
             n_paths, n_chars, sb.n_invalid);
    $display("checked %0d result beats, %0d with errors", sb.n_checked, sb.errors);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
